// ----- design/ctcb_pkg.sv -----
// Shared types and constants for the call trace capture buffer.
`default_nettype none

package ctcb_pkg;

    // Default sizes
    localparam int RING_ENTRIES_DEF = 256;
    localparam int STACK_DEPTH_DEF  = 32;

    // Field widths
    localparam int ADDR_W   = 64;
    localparam int CNT_W    = 32;
    localparam int OFF_W    = 8;
    localparam int DEPTH_W  = 6;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_CALL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAPH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FCOUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_F0_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_F0_END   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_F1_START = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_F1_END   = 3'd6;

    // One trace record
    typedef struct packed {
        logic [ADDR_W-1:0] func;
        logic [ADDR_W-1:0] caller;
        logic [ADDR_W-1:0] stamp;
    } t_rec;

    // Requests from the sequencer to the ring
    typedef struct packed {
        logic rd_req;   // look up a record (accept cycle)
        logic wr_req;   // append a record (completion cycle)
        logic clr;      // empty the ring (completion cycle)
    } t_ring_ctl;

    // Ring status back to the sequencer
    typedef struct packed {
        logic             rd_valid;
        logic             overwrote;
        logic [CNT_W-1:0] drop_total;
        logic [CNT_W-1:0] write_total;
    } t_ring_stat;

endpackage

`default_nettype wire

// ----- design/ctcb_ring.sv -----
// Circular trace store: record memory, head/tail pointers and totals.
`default_nettype none

module ctcb_ring #(
    parameter int RING_ENTRIES = ctcb_pkg::RING_ENTRIES_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  ctcb_pkg::t_ring_ctl            i_ctl,
    input  wire  [ctcb_pkg::OFF_W-1:0]     i_rd_offset,
    input  ctcb_pkg::t_rec                 i_wr_rec,
    output ctcb_pkg::t_ring_stat           o_stat,
    output ctcb_pkg::t_rec                 o_rd_rec
);

    localparam int IW = $clog2(RING_ENTRIES);
    localparam int CW = IW + 1;
    localparam int SW = ((IW > ctcb_pkg::OFF_W) ? IW : ctcb_pkg::OFF_W) + 1;

    ctcb_pkg::t_rec r_mem [RING_ENTRIES];
    ctcb_pkg::t_rec r_rd_rec;
    logic           r_rd_valid;

    logic [IW-1:0]             r_head, n_head;
    logic [IW-1:0]             r_tail, n_tail;
    logic [ctcb_pkg::CNT_W-1:0] r_drop, n_drop;
    logic [ctcb_pkg::CNT_W-1:0] r_wcnt, n_wcnt;

    logic [IW-1:0] w_head_nx;
    logic [IW-1:0] w_tail_nx;
    logic          w_full;
    logic [CW-1:0] w_count;
    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_idx;
    logic          w_hit;

    // Slot advance with wrap
    assign w_head_nx = (r_head == IW'(RING_ENTRIES - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_nx = (r_tail == IW'(RING_ENTRIES - 1)) ? '0 : r_tail + 1'b1;
    assign w_full    = (w_head_nx == r_tail);

    // Records held; one slot always stays empty
    always_comb begin
        if (r_head >= r_tail) begin
            w_count = CW'(r_head) - CW'(r_tail);
        end else begin
            w_count = CW'(RING_ENTRIES) - CW'(r_tail) + CW'(r_head);
        end
    end

    assign w_hit = SW'(i_rd_offset) < SW'(w_count);
    assign w_sum = SW'(r_tail) + SW'(i_rd_offset);
    assign w_idx = (w_sum >= SW'(RING_ENTRIES)) ? w_sum - SW'(RING_ENTRIES) : w_sum;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_drop = r_drop;
        n_wcnt = r_wcnt;
        if (i_ctl.clr) begin
            n_head = '0;
            n_tail = '0;
            n_drop = '0;
            n_wcnt = '0;
        end else if (i_ctl.wr_req) begin
            n_head = w_head_nx;
            if (w_full) begin
                n_tail = w_tail_nx;
                if (r_drop != '1) begin
                    n_drop = r_drop + 1'b1;
                end
            end
            if (r_wcnt != '1) begin
                n_wcnt = r_wcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_drop     <= '0;
            r_wcnt     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_drop <= n_drop;
            r_wcnt <= n_wcnt;
            if (i_ctl.rd_req) begin
                r_rd_valid <= w_hit;
            end
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_req && !i_ctl.clr) begin
            r_mem[r_head] <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_req && w_hit) begin
            r_rd_rec <= r_mem[w_idx[IW-1:0]];
        end
    end

    assign o_stat.rd_valid    = r_rd_valid;
    assign o_stat.overwrote   = i_ctl.wr_req && !i_ctl.clr && w_full;
    assign o_stat.drop_total  = n_drop;
    assign o_stat.write_total = n_wcnt;
    assign o_rd_rec           = r_rd_rec;

endmodule

`default_nettype wire

// ----- design/call_trace_capture_buffer.sv -----
// Call trace capture buffer: top level with sequencer, call stack and config.
// Flow: IDLE captures an accepted item, EXEC completes it into the output register when
//   that register is free, and only then is a new item taken. The memory read in the
//   accept cycle and the read-modify-write in the completion cycle share one slot.
// Reset: synchronous, active low; clears pointers, totals, depth, config and handshake
//   state. Record and stack memories are not cleared; unwritten entries are never read.
`default_nettype none

module call_trace_capture_buffer #(
    parameter int RING_ENTRIES = ctcb_pkg::RING_ENTRIES_DEF,
    parameter int STACK_DEPTH  = ctcb_pkg::STACK_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write port
    input  wire                                 i_cfg_we,
    input  wire  [ctcb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [ctcb_pkg::ADDR_W-1:0]         i_cfg_data,
    // input item channel
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [ctcb_pkg::CMD_W-1:0]          i_cmd,
    input  wire  [ctcb_pkg::ADDR_W-1:0]         i_func_addr,
    input  wire  [ctcb_pkg::ADDR_W-1:0]         i_caller_addr,
    input  wire  [ctcb_pkg::ADDR_W-1:0]         i_time_now,
    input  wire  [ctcb_pkg::OFF_W-1:0]          i_read_offset,
    // result item channel
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic                                o_recorded,
    output logic                                o_overwrote,
    output logic [ctcb_pkg::CNT_W-1:0]          o_drop_total,
    output logic [ctcb_pkg::CNT_W-1:0]          o_write_total,
    output logic [ctcb_pkg::DEPTH_W-1:0]        o_stack_depth,
    output logic                                o_return_matched,
    output logic [ctcb_pkg::ADDR_W-1:0]         o_call_duration,
    output logic                                o_read_valid,
    output logic [ctcb_pkg::ADDR_W-1:0]         o_read_func,
    output logic [ctcb_pkg::ADDR_W-1:0]         o_read_caller,
    output logic [ctcb_pkg::ADDR_W-1:0]         o_read_time
);

    // Stack sizing: depth counter holds 0..STACK_DEPTH, address needs at least one bit
    localparam int DCW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int XW  = (DCW > ctcb_pkg::DEPTH_W) ? DCW : ctcb_pkg::DEPTH_W;

    // One call stack frame
    typedef struct packed {
        logic [ctcb_pkg::ADDR_W-1:0] func;
        logic [ctcb_pkg::ADDR_W-1:0] stamp;
    } t_frame;

    // Sequencer: IDLE takes an item and issues memory reads,
    // EXEC finishes it once the output register is free
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic                        r_trace_en;
    logic                        r_graph;
    logic [1:0]                  r_fcount;
    logic [ctcb_pkg::ADDR_W-1:0] r_f0_lo, r_f0_hi, r_f1_lo, r_f1_hi;

    // Captured item
    logic [ctcb_pkg::CMD_W-1:0]  r_cmd;
    logic [ctcb_pkg::ADDR_W-1:0] r_func;
    logic [ctcb_pkg::ADDR_W-1:0] r_caller;
    logic [ctcb_pkg::ADDR_W-1:0] r_time;
    logic                        r_pass;

    // Call stack
    t_frame          r_stack [STACK_DEPTH];
    t_frame          r_top;
    logic [DCW-1:0]  r_depth, n_depth;

    // Output register
    logic                        r_out_valid;
    logic                        r_recorded;
    logic                        r_overwrote;
    logic [ctcb_pkg::CNT_W-1:0]  r_drop_total;
    logic [ctcb_pkg::CNT_W-1:0]  r_write_total;
    logic [ctcb_pkg::DEPTH_W-1:0] r_stack_depth;
    logic                        r_matched;
    logic [ctcb_pkg::ADDR_W-1:0] r_duration;
    logic                        r_read_valid;
    logic [ctcb_pkg::ADDR_W-1:0] r_read_func;
    logic [ctcb_pkg::ADDR_W-1:0] r_read_caller;
    logic [ctcb_pkg::ADDR_W-1:0] r_read_time;

    logic                 w_accept;
    logic                 w_done;
    logic                 w_pass;
    logic                 w_call;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_match;
    logic [SAW-1:0]       w_pop_addr;
    logic [XW-1:0]        w_depth_x;
    logic [ctcb_pkg::ADDR_W-1:0] w_dur;

    ctcb_pkg::t_ring_ctl  w_ring_ctl;
    ctcb_pkg::t_ring_stat w_ring_stat;
    ctcb_pkg::t_rec       w_wr_rec;
    ctcb_pkg::t_rec       w_rd_rec;

    // ---------------------------------------------------------------
    // Handshake: one item in flight; the output register lets the next
    // item be taken while a result still waits downstream. No item is
    // taken while reset is held.
    // ---------------------------------------------------------------
    assign o_ready  = (r_state == S_IDLE) && i_rst_n;
    assign w_accept = i_valid && o_ready;
    assign w_done   = (r_state == S_EXEC) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_done)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Address filter, evaluated on the incoming item. Ranges are
    // half-open; an empty or inverted range passes nothing. A filter
    // count of three behaves as two.
    // ---------------------------------------------------------------
    always_comb begin
        logic hit0;
        logic hit1;
        hit0 = (i_func_addr >= r_f0_lo) && (i_func_addr < r_f0_hi);
        hit1 = (i_func_addr >= r_f1_lo) && (i_func_addr < r_f1_hi);
        if (r_fcount == 2'd0) begin
            w_pass = 1'b1;
        end else begin
            w_pass = hit0 || (r_fcount[1] && hit1);
        end
    end

    // ---------------------------------------------------------------
    // Completion-cycle decisions
    // ---------------------------------------------------------------
    assign w_call  = (r_cmd == ctcb_pkg::CMD_CALL) && r_trace_en && r_pass;
    assign w_push  = w_call && r_graph && (r_depth < DCW'(STACK_DEPTH));
    assign w_pop   = (r_cmd == ctcb_pkg::CMD_RET) && r_trace_en && r_graph
                     && (r_depth != '0);
    assign w_match = w_pop && (r_top.func == r_func);
    assign w_dur   = r_time - r_top.stamp;

    // Top-of-stack address for the read issued at accept time
    assign w_pop_addr = SAW'(DCW'(r_depth - 1'b1));

    always_comb begin
        n_depth = r_depth;
        if (w_done) begin
            if (r_cmd == ctcb_pkg::CMD_CLEAR) begin
                n_depth = '0;
            end else if (w_push) begin
                n_depth = r_depth + 1'b1;
            end else if (w_pop) begin
                n_depth = r_depth - 1'b1;
            end
        end
    end

    // Reported depth wraps at 64
    assign w_depth_x = XW'(n_depth);

    // ---------------------------------------------------------------
    // Ring store
    // ---------------------------------------------------------------
    assign w_ring_ctl.rd_req = w_accept && (i_cmd == ctcb_pkg::CMD_READ);
    assign w_ring_ctl.wr_req = w_done && w_call;
    assign w_ring_ctl.clr    = w_done && (r_cmd == ctcb_pkg::CMD_CLEAR);

    assign w_wr_rec.func   = r_func;
    assign w_wr_rec.caller = r_caller;
    assign w_wr_rec.stamp  = r_time;

    ctcb_ring #(
        .RING_ENTRIES (RING_ENTRIES)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ring_ctl),
        .i_rd_offset (i_read_offset),
        .i_wr_rec    (w_wr_rec),
        .o_stat      (w_ring_stat),
        .o_rd_rec    (w_rd_rec)
    );

    // ---------------------------------------------------------------
    // Call stack memory: pushed in the completion cycle, top read at
    // accept for a return. One item at a time, so the two never meet.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_done && w_push) begin
            r_stack[r_depth[SAW-1:0]] <= '{func: r_func, stamp: r_time};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_cmd == ctcb_pkg::CMD_RET) && (r_depth != '0)) begin
            r_top <= r_stack[w_pop_addr];
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            r_trace_en  <= 1'b0;
            r_graph     <= 1'b0;
            r_fcount    <= '0;
            r_f0_lo     <= '0;
            r_f0_hi     <= '0;
            r_f1_lo     <= '0;
            r_f1_hi     <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ctcb_pkg::REG_TRACE_EN: r_trace_en <= i_cfg_data[0];
                    ctcb_pkg::REG_GRAPH:    r_graph    <= i_cfg_data[0];
                    ctcb_pkg::REG_FCOUNT:   r_fcount   <= i_cfg_data[1:0];
                    ctcb_pkg::REG_F0_START: r_f0_lo    <= i_cfg_data;
                    ctcb_pkg::REG_F0_END:   r_f0_hi    <= i_cfg_data;
                    ctcb_pkg::REG_F1_START: r_f1_lo    <= i_cfg_data;
                    ctcb_pkg::REG_F1_END:   r_f1_hi    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_cmd;
            r_func   <= i_func_addr;
            r_caller <= i_caller_addr;
            r_time   <= i_time_now;
            r_pass   <= w_pass;
        end
    end

    // Result register; fields that do not apply to the command read zero
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_recorded    <= w_call;
            r_overwrote   <= w_ring_stat.overwrote;
            r_drop_total  <= w_ring_stat.drop_total;
            r_write_total <= w_ring_stat.write_total;
            r_stack_depth <= w_depth_x[ctcb_pkg::DEPTH_W-1:0];
            r_matched     <= w_match;
            r_duration    <= w_match ? w_dur : '0;
            if ((r_cmd == ctcb_pkg::CMD_READ) && w_ring_stat.rd_valid) begin
                r_read_valid  <= 1'b1;
                r_read_func   <= w_rd_rec.func;
                r_read_caller <= w_rd_rec.caller;
                r_read_time   <= w_rd_rec.stamp;
            end else begin
                r_read_valid  <= 1'b0;
                r_read_func   <= '0;
                r_read_caller <= '0;
                r_read_time   <= '0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_recorded       = r_recorded;
    assign o_overwrote      = r_overwrote;
    assign o_drop_total     = r_drop_total;
    assign o_write_total    = r_write_total;
    assign o_stack_depth    = r_stack_depth;
    assign o_return_matched = r_matched;
    assign o_call_duration  = r_duration;
    assign o_read_valid     = r_read_valid;
    assign o_read_func      = r_read_func;
    assign o_read_caller    = r_read_caller;
    assign o_read_time      = r_read_time;

endmodule

`default_nettype wire

// ----- verif/call_trace_capture_buffer_tb.sv -----
// Self-checking testbench for the call trace capture buffer, with its own predictor.
module call_trace_capture_buffer_tb;
    import ctcb_pkg::*;

    // Sizes the predictor mirrors; the block is built with its defaults.
    localparam int RING_N = RING_ENTRIES_DEF;    // 256: 8-bit pointers wrap by themselves
    localparam int STACK_N = STACK_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 300000;        // far above the slowest legal run
    localparam int HOLD_CYCLES = 400;            // long receiver hold-off that backs up input
    localparam int SETTLE_CYCLES = 8;            // tail after the last result

    // One input item as driven on the ports
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] fn;
        logic [ADDR_W-1:0] site;
        logic [ADDR_W-1:0] stamp;
        logic [OFF_W-1:0]  off;
    } trace_item_t;

    // One result item, field for field with the output ports
    typedef struct packed {
        logic               rec;
        logic               ovw;
        logic [CNT_W-1:0]   drops;
        logic [CNT_W-1:0]   writes;
        logic [DEPTH_W-1:0] depth;
        logic               matched;
        logic [ADDR_W-1:0]  dur;
        logic               rvalid;
        logic [ADDR_W-1:0]  rfn;
        logic [ADDR_W-1:0]  rsite;
        logic [ADDR_W-1:0]  rstamp;
    } trace_result_t;

    // ---------------------------------------------------------------- DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ADDR_W-1:0]    i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [ADDR_W-1:0]    i_func_addr = '0;
    logic [ADDR_W-1:0]    i_caller_addr = '0;
    logic [ADDR_W-1:0]    i_time_now = '0;
    logic [OFF_W-1:0]     i_read_offset = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_recorded;
    logic                 o_overwrote;
    logic [CNT_W-1:0]     o_drop_total;
    logic [CNT_W-1:0]     o_write_total;
    logic [DEPTH_W-1:0]   o_stack_depth;
    logic                 o_return_matched;
    logic [ADDR_W-1:0]    o_call_duration;
    logic                 o_read_valid;
    logic [ADDR_W-1:0]    o_read_func;
    logic [ADDR_W-1:0]    o_read_caller;
    logic [ADDR_W-1:0]    o_read_time;

    call_trace_capture_buffer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_func_addr      (i_func_addr),
        .i_caller_addr    (i_caller_addr),
        .i_time_now       (i_time_now),
        .i_read_offset    (i_read_offset),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_recorded       (o_recorded),
        .o_overwrote      (o_overwrote),
        .o_drop_total     (o_drop_total),
        .o_write_total    (o_write_total),
        .o_stack_depth    (o_stack_depth),
        .o_return_matched (o_return_matched),
        .o_call_duration  (o_call_duration),
        .o_read_valid     (o_read_valid),
        .o_read_func      (o_read_func),
        .o_read_caller    (o_read_caller),
        .o_read_time      (o_read_time)
    );

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor state
    // Register shadows, updated only while the block is idle
    logic              cfg_en = 1'b0;
    logic              cfg_graph = 1'b0;
    logic [1:0]        cfg_nfilt = '0;
    logic [ADDR_W-1:0] cfg_lo [2] = '{default: '0};
    logic [ADDR_W-1:0] cfg_hi [2] = '{default: '0};

    // Trace store: wr_ptr is the next free slot, rd_ptr the oldest record.
    logic [ADDR_W-1:0] shadow_fn    [RING_N];
    logic [ADDR_W-1:0] shadow_site  [RING_N];
    logic [ADDR_W-1:0] shadow_stamp [RING_N];
    logic [OFF_W-1:0]  wr_ptr = '0;
    logic [OFF_W-1:0]  rd_ptr = '0;
    logic [CNT_W-1:0]  drops = '0;
    logic [CNT_W-1:0]  writes = '0;

    // Graph call stack
    logic [ADDR_W-1:0] nest_fn    [STACK_N];
    logic [ADDR_W-1:0] nest_stamp [STACK_N];
    int                nest_depth = 0;

    // ---------------------------------------------------------------- bookkeeping
    trace_item_t   item_q[$];        // items waiting for the driver
    trace_result_t expected_q[$];    // predicted results, oldest first
    int            in_flight = 0;    // items queued but not yet checked
    int            fail_count = 0;
    int            n_items = 0;
    int            n_results = 0;
    int            n_stored = 0;
    int            n_overwrites = 0;
    int            n_matched = 0;
    int            n_reads = 0;
    int            cycles = 0;
    logic          in_taken = 1'b0;  // input item accepted at the last rising edge
    logic          idle_on = 1'b1;   // random gaps on both sides
    int            hold_req = 0;     // bumped by the stimulus to ask for a long hold-off

    // Generator view of the block, so returns can match and reads can hit
    logic [ADDR_W-1:0] gen_nest[$];
    int                gen_held = 0;
    logic [ADDR_W-1:0] gen_clock = '0;

    // Either range may pass the address; a count of three acts as two.
    function automatic logic addr_passes(logic [ADDR_W-1:0] a);
        if (cfg_nfilt == 2'd0)
            return 1'b1;
        if (a >= cfg_lo[0] && a < cfg_hi[0])
            return 1'b1;
        if (cfg_nfilt >= 2'd2 && a >= cfg_lo[1] && a < cfg_hi[1])
            return 1'b1;
        return 1'b0;
    endfunction

    // Advance the predicted state by one item and return its result.
    function automatic trace_result_t trace_step(trace_item_t it);
        trace_result_t    r;
        logic [OFF_W-1:0] nxt;
        logic [OFF_W-1:0] held;
        logic [OFF_W-1:0] idx;
        r = '0;
        case (it.cmd)
            CMD_CALL: begin
                if (cfg_en && addr_passes(it.fn)) begin
                    nxt = wr_ptr + 1'b1;
                    // full stack: still stored, just not pushed
                    if (cfg_graph && nest_depth < STACK_N) begin
                        nest_fn[nest_depth] = it.fn;
                        nest_stamp[nest_depth] = it.stamp;
                        nest_depth++;
                    end
                    // one slot stays free, so a full store drops its oldest record
                    if (nxt == rd_ptr) begin
                        rd_ptr = rd_ptr + 1'b1;
                        if (drops != '1)
                            drops = drops + 1'b1;
                        r.ovw = 1'b1;
                    end
                    shadow_fn[wr_ptr] = it.fn;
                    shadow_site[wr_ptr] = it.site;
                    shadow_stamp[wr_ptr] = it.stamp;
                    wr_ptr = nxt;
                    if (writes != '1)
                        writes = writes + 1'b1;
                    r.rec = 1'b1;
                end
            end
            CMD_RET: begin
                // unfiltered; an unmatched return still pops
                if (cfg_en && cfg_graph && nest_depth > 0) begin
                    nest_depth--;
                    if (nest_fn[nest_depth] == it.fn) begin
                        r.matched = 1'b1;
                        r.dur = it.stamp - nest_stamp[nest_depth];
                    end
                end
            end
            CMD_CLEAR: begin
                wr_ptr = '0;
                rd_ptr = '0;
                drops = '0;
                writes = '0;
                nest_depth = 0;
            end
            default: begin
                held = wr_ptr - rd_ptr;
                if (it.off < held) begin
                    idx = rd_ptr + it.off;
                    r.rvalid = 1'b1;
                    r.rfn = shadow_fn[idx];
                    r.rsite = shadow_site[idx];
                    r.rstamp = shadow_stamp[idx];
                end
            end
        endcase
        r.drops = drops;
        r.writes = writes;
        r.depth = DEPTH_W'(nest_depth);
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch in result %0d, %s: expected %h, got %h",
                         n_results, name, want, got);
        end
    endfunction

    // ---------------------------------------------------------------- driver
    trace_item_t cur_item = '0;
    int          src_gap = 0;

    always @(negedge i_clk) begin : drive_items
        logic offer;
        offer = i_valid;
        // a held item stays on the ports until it is taken
        if (!i_valid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                offer = 1'b0;
            end else if (item_q.size() == 0) begin
                offer = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(0, 14);
                offer = 1'b0;
            end else begin
                cur_item = item_q.pop_front();
                offer = 1'b1;
            end
        end
        i_valid <= offer;
        i_cmd <= cur_item.cmd;
        i_func_addr <= cur_item.fn;
        i_caller_addr <= cur_item.site;
        i_time_now <= cur_item.stamp;
        i_read_offset <= cur_item.off;
    end

    // ---------------------------------------------------------------- receiver
    int hold_left = 0;
    int hold_seen = 0;
    int sink_gap = 0;

    always @(negedge i_clk) begin : drive_sink
        logic take;
        take = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            take = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            take = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 14);
            take = 1'b0;
        end
        i_ready <= take;
    end

    // ---------------------------------------------------------------- monitor
    // Both handshakes are sampled at the rising edge on pre-edge values.
    always @(posedge i_clk) begin : watch_ports
        trace_item_t   it;
        trace_result_t want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                it.cmd = i_cmd;
                it.fn = i_func_addr;
                it.site = i_caller_addr;
                it.stamp = i_time_now;
                it.off = i_read_offset;
                expected_q.push_back(trace_step(it));
                n_items++;
            end
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with nothing pending after %0d results", n_results);
                end else begin
                    want = expected_q.pop_front();
                    check_field("recorded", 64'(want.rec), 64'(o_recorded));
                    check_field("overwrote", 64'(want.ovw), 64'(o_overwrote));
                    check_field("drop_total", 64'(want.drops), 64'(o_drop_total));
                    check_field("write_total", 64'(want.writes), 64'(o_write_total));
                    check_field("stack_depth", 64'(want.depth), 64'(o_stack_depth));
                    check_field("return_matched", 64'(want.matched), 64'(o_return_matched));
                    check_field("call_duration", want.dur, o_call_duration);
                    check_field("read_valid", 64'(want.rvalid), 64'(o_read_valid));
                    check_field("read_func", want.rfn, o_read_func);
                    check_field("read_caller", want.rsite, o_read_caller);
                    check_field("read_time", want.rstamp, o_read_time);
                    n_results++;
                    n_stored += want.rec;
                    n_overwrites += want.ovw;
                    n_matched += want.matched;
                    n_reads += want.rvalid;
                    in_flight--;
                end
            end
        end
        in_taken <= i_valid && o_ready && i_rst_n;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d items still open", cycles, in_flight);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus helpers
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_TRACE_EN: cfg_en = val[0];
            REG_GRAPH:    cfg_graph = val[0];
            REG_FCOUNT:   cfg_nfilt = val[1:0];
            REG_F0_START: cfg_lo[0] = val;
            REG_F0_END:   cfg_hi[0] = val;
            REG_F1_START: cfg_lo[1] = val;
            REG_F1_END:   cfg_hi[1] = val;
            default: ;
        endcase
    endtask

    // All seven registers, back to back; only called while idle.
    task automatic set_regs(logic en, logic graph, logic [1:0] nfilt,
                            logic [ADDR_W-1:0] lo0, logic [ADDR_W-1:0] hi0,
                            logic [ADDR_W-1:0] lo1, logic [ADDR_W-1:0] hi1);
        write_reg(REG_TRACE_EN, ADDR_W'(en));
        write_reg(REG_GRAPH, ADDR_W'(graph));
        write_reg(REG_FCOUNT, ADDR_W'(nfilt));
        write_reg(REG_F0_START, lo0);
        write_reg(REG_F0_END, hi0);
        write_reg(REG_F1_START, lo1);
        write_reg(REG_F1_END, hi1);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void push_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] fn,
                                      logic [ADDR_W-1:0] site, logic [ADDR_W-1:0] stamp,
                                      logic [OFF_W-1:0] off);
        trace_item_t it;
        it.cmd = cmd;
        it.fn = fn;
        it.site = site;
        it.stamp = stamp;
        it.off = off;
        item_q.push_back(it);
        in_flight++;
    endfunction

    // Wait until every queued item has its result checked.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (in_flight != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // Addresses biased to the filter edges, inside the ranges, or anywhere.
    function automatic logic [ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(0, 1);
        case ($urandom_range(0, 4))
            0: return cfg_lo[r] + ADDR_W'($urandom_range(0, 8)) - 64'd4;
            1: return cfg_hi[r] + ADDR_W'($urandom_range(0, 8)) - 64'd4;
            2, 3: begin
                if (cfg_hi[r] > cfg_lo[r])
                    return cfg_lo[r] + ({$urandom, $urandom} % (cfg_hi[r] - cfg_lo[r]));
                return {$urandom, $urandom};
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random items with weights in percent; the rest are clears. Returns mostly
    // name the function on top of the stack, so nesting goes deep.
    task automatic queue_random(int n, int w_call, int w_ret, int w_read);
        trace_item_t it;
        int          pick;
        gen_held = int'(OFF_W'(wr_ptr - rd_ptr));
        gen_nest.delete();
        for (int k = 0; k < nest_depth; k++)
            gen_nest.push_back(nest_fn[k]);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            it.site = {$urandom, $urandom};
            it.fn = pick_addr();
            it.off = OFF_W'($urandom);
            if ($urandom_range(0, 19) == 0)
                gen_clock = {$urandom, $urandom};
            else
                gen_clock = gen_clock + ADDR_W'($urandom_range(1, 500));
            it.stamp = gen_clock;
            if (pick < w_call) begin
                it.cmd = CMD_CALL;
                if (cfg_en && addr_passes(it.fn)) begin
                    if (gen_held < RING_N - 1)
                        gen_held++;
                    if (cfg_graph && gen_nest.size() < STACK_N)
                        gen_nest.push_back(it.fn);
                end
            end else if (pick < w_call + w_ret) begin
                it.cmd = CMD_RET;
                if (gen_nest.size() != 0 && $urandom_range(0, 4) != 0)
                    it.fn = gen_nest[$];
                if (cfg_en && cfg_graph && gen_nest.size() != 0)
                    void'(gen_nest.pop_back());
            end else if (pick < w_call + w_ret + w_read) begin
                it.cmd = CMD_READ;
                case ($urandom_range(0, 4))
                    0, 1, 2: if (gen_held > 0) it.off = OFF_W'($urandom_range(0, gen_held - 1));
                    3: it.off = OFF_W'(gen_held);    // first slot past the records
                    default: ;
                endcase
            end else begin
                it.cmd = CMD_CLEAR;
                gen_held = 0;
                gen_nest.delete();
            end
            item_q.push_back(it);
            in_flight++;
        end
    endtask

    // ---------------------------------------------------------------- test sequence
    initial begin : stimulus
        logic [ADDR_W-1:0] lo_a;
        logic [ADDR_W-1:0] lo_b;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset tracing is off: call and return do nothing,
        // read and clear still act.
        push_item(CMD_CALL, 64'h10, 64'h20, 64'h30, 8'd0);
        push_item(CMD_RET, 64'h10, 64'h0, 64'h40, 8'd0);
        push_item(CMD_READ, 64'h0, 64'h0, 64'h0, 8'd0);
        push_item(CMD_CLEAR, 64'h0, 64'h0, 64'h0, 8'd0);
        wait_idle();

        // Graph mode, no filter: field extremes, matched return with a wrapping
        // duration, unmatched return, return on an empty stack, reads in and out.
        set_regs(1'b1, 1'b1, 2'd0, 64'h0, '1, '1, '1);
        push_item(CMD_CALL, 64'h0, '1, 64'h0, 8'd0);
        push_item(CMD_CALL, '1, 64'h0, '1, 8'd255);
        push_item(CMD_READ, 64'h0, 64'h0, 64'h0, 8'd0);
        push_item(CMD_READ, 64'h0, 64'h0, 64'h0, 8'd1);
        push_item(CMD_READ, 64'h0, 64'h0, 64'h0, 8'd2);
        push_item(CMD_READ, '1, '1, '1, 8'd255);
        push_item(CMD_RET, '1, 64'h0, 64'h5, 8'd0);
        push_item(CMD_RET, 64'h1, 64'h0, 64'h9, 8'd0);
        push_item(CMD_RET, 64'h0, 64'h0, 64'hA, 8'd0);
        push_item(CMD_CLEAR, 64'h0, 64'h0, 64'h0, 8'd0);
        push_item(CMD_READ, 64'h0, 64'h0, 64'h0, 8'd0);
        wait_idle();

        // One filter, plain mode: range edges; range one is ignored, returns too.
        set_regs(1'b1, 1'b0, 2'd1, 64'h1000, 64'h2000, 64'h3000, 64'h4000);
        push_item(CMD_CALL, 64'h0FFF, 64'h1, 64'h100, 8'd0);
        push_item(CMD_CALL, 64'h1000, 64'h2, 64'h101, 8'd0);
        push_item(CMD_CALL, 64'h1FFF, 64'h3, 64'h102, 8'd0);
        push_item(CMD_CALL, 64'h2000, 64'h4, 64'h103, 8'd0);
        push_item(CMD_CALL, 64'h3000, 64'h5, 64'h104, 8'd0);
        push_item(CMD_RET, 64'h1000, 64'h0, 64'h105, 8'd0);
        wait_idle();

        // Filter count of three acts as two; range zero is empty (end below start).
        set_regs(1'b1, 1'b1, 2'd3, 64'h2000, 64'h1000, 64'h3000, 64'h4000);
        push_item(CMD_CALL, 64'h1800, 64'h6, 64'h200, 8'd0);
        push_item(CMD_CALL, 64'h3000, 64'h7, 64'h201, 8'd0);
        push_item(CMD_CALL, 64'h3FFF, 64'h8, 64'h202, 8'd0);
        push_item(CMD_CALL, 64'h4000, 64'h9, 64'h203, 8'd0);
        wait_idle();

        // Random part. Graph nesting with no filter, register extremes.
        set_regs(1'b1, 1'b1, 2'd0, 64'h0, '1, '1, 64'h0);
        queue_random(150, 40, 35, 20);
        wait_idle();

        // Plain mode, no clears: the store wraps and overwrites its oldest records.
        set_regs(1'b1, 1'b0, 2'd0, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        queue_random(450, 75, 5, 20);
        wait_idle();

        // One random window
        lo_a = {$urandom, $urandom};
        lo_b = {$urandom, $urandom};
        set_regs(1'b1, 1'b1, 2'd1, lo_a, lo_a + 64'($urandom_range(16, 4096)),
                 lo_b, lo_b + 64'($urandom_range(16, 4096)));
        queue_random(120, 45, 30, 20);
        wait_idle();

        // Two windows, and the receiver holds off long enough that the block
        // backs up and stalls its input while the sender keeps offering.
        lo_a = {$urandom, $urandom};
        lo_b = {$urandom, $urandom};
        set_regs(1'b1, 1'b1, 2'd2, lo_a, lo_a + 64'($urandom_range(16, 4096)),
                 lo_b, lo_b + 64'($urandom_range(16, 4096)));
        idle_on = 1'b0;
        queue_random(120, 45, 30, 20);
        hold_req++;
        wait_idle();
        idle_on = 1'b1;

        // Count of three, ranges touching both ends of the address space
        lo_b = {$urandom, $urandom};
        set_regs(1'b1, 1'b1, 2'd3, 64'h0, 64'($urandom_range(16, 4096)), lo_b, '1);
        queue_random(100, 45, 30, 20);
        wait_idle();

        // Tracing off: only reads and clears act
        set_regs(1'b0, 1'b1, 2'($urandom_range(0, 3)), {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        queue_random(60, 40, 30, 25);
        wait_idle();

        // Both ranges empty: every call is filtered out, returns still pop
        lo_a = {$urandom, $urandom};
        lo_b = {$urandom, $urandom} | 64'h1;
        set_regs(1'b1, 1'b1, 2'd2, lo_a, lo_a, lo_b, lo_b - 64'd1);
        queue_random(60, 50, 25, 20);
        wait_idle();

        // Last stretch without idling: call heavy, so the stack runs full.
        idle_on = 1'b0;
        set_regs(1'b1, 1'b1, 2'd0, '1, 64'h0, 64'h0, '1);
        queue_random(150, 60, 15, 25);
        wait_idle();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("%0d items, %0d results: %0d calls stored, %0d overwrites, %0d returns matched, %0d reads hit",
                 n_items, n_results, n_stored, n_overwrites, n_matched, n_reads);
        $display("covered tracing off, plain and graph mode, zero to three filters, empty ranges, full store and stack");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
design/ctcb_pkg.sv
design/ctcb_ring.sv
design/call_trace_capture_buffer.sv
verif/call_trace_capture_buffer_tb.sv
